@@ sv/pitts_pkg.sv @@
// shared types and constants for the program image to text stream block
// no dependencies; used by pitts_bcd_conv and program_image_to_text_stream
`default_nettype none
package pitts_pkg;

	localparam int LINE_W     = 16;
	localparam int BCD_DIGITS = 5;
	localparam int BCD_W      = 4 * BCD_DIGITS;
	localparam int COUNT_W    = 9;

	// header byte position codes
	localparam logic [1:0] HDR_LOW  = 2'd0;
	localparam logic [1:0] HDR_HIGH = 2'd1;
	localparam logic [1:0] HDR_LEN  = 2'd2;
	localparam logic [1:0] HDR_TEXT = 2'd3;

	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_DIGIT,
		ST_SPACE,
		ST_TEXT,
		ST_CR,
		ST_LF
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} bcd_status_t;

	// double dabble correction of one bcd digit
	function automatic logic [3:0] add3(input logic [3:0] d);
		return (d >= 4'd5) ? 4'(d + 4'd3) : d;
	endfunction

endpackage
`default_nettype wire

@@ sv/pitts_bcd_conv.sv @@
// bit-serial binary to bcd converter (shift and add-3), one bit per cycle
// depends on pitts_pkg
`default_nettype none
module pitts_bcd_conv (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	input  wire logic [pitts_pkg::LINE_W-1:0]    value,
	output pitts_pkg::bcd_status_t               status,
	output logic      [pitts_pkg::BCD_W-1:0]     digits
);

	localparam int CNT_W = $clog2(pitts_pkg::LINE_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(pitts_pkg::LINE_W - 1);

	logic [pitts_pkg::LINE_W-1:0] bin_q;
	logic [pitts_pkg::BCD_W-1:0]  bcd_q;
	logic [pitts_pkg::BCD_W-1:0]  adj;
	logic [CNT_W-1:0]             cnt_q;
	logic                         busy_q;
	logic                         done_q;

	always_comb begin
		for (int i = 0; i < pitts_pkg::BCD_DIGITS; i++) begin
			adj[4*i +: 4] = pitts_pkg::add3(bcd_q[4*i +: 4]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_LAST);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= value;
			bcd_q <= '0;
		end else if (busy_q) begin
			bin_q <= {bin_q[pitts_pkg::LINE_W-2:0], 1'b0};
			bcd_q <= {adj[pitts_pkg::BCD_W-2:0], bin_q[pitts_pkg::LINE_W-1]};
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign digits      = bcd_q;

endmodule
`default_nettype wire

@@ sv/program_image_to_text_stream.sv @@
// top level: program image bytes in, listing characters out
// depends on pitts_pkg and pitts_bcd_conv
`default_nettype none
// usage:
//   input channel: data_byte and start_of_file with in_valid / in_stall; an
//   item is taken on a clock edge with in_valid high and in_stall low.
//   output channel: out_char and last with out_valid / out_stall; last marks
//   the final character caused by one input item.
//   header bytes one and two are silent and leave the block idle, as does a
//   length byte with line number zero and any byte after the end of program.
//   a length byte starts a bit-serial decimal conversion of the line number:
//   all 16 bits are shifted in, the done flag is awaited, then the five digit
//   positions are stepped through (leading zeros give no output), then the
//   space is emitted and the block returns to idle.
//   a nonzero text byte goes to the text state, which puts its character into
//   the output register; closing the record adds the CR and LF states after it.
//   a dropped zero byte keeps the block idle unless it closes its record.
//   in_stall is high while a character sequence is being produced; the next
//   item is taken while the last character still sits in the output register.
//   a stalled receiver holds the output register and the block waits.
//   reset clears all record state and output valid; start_of_file clears the
//   record and end state before its byte is taken.
module program_image_to_text_stream (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] data_byte,
	input  wire logic       start_of_file,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      out_char,
	output logic            last
);

	localparam int DCNT_W = $clog2(pitts_pkg::BCD_DIGITS);
	localparam logic [DCNT_W-1:0] DIGIT_LAST = DCNT_W'(pitts_pkg::BCD_DIGITS - 1);

	pitts_pkg::state_t state_q, state_d;

	// record state
	logic [1:0]                      hdr_q;
	logic [7:0]                      low_q;
	logic [7:0]                      high_q;
	logic [pitts_pkg::COUNT_W-1:0]   target_q;
	logic [pitts_pkg::COUNT_W-1:0]   done_q;
	logic                            ended_q;

	// pending text byte and whether it closes its record
	logic [7:0] text_q;
	logic       close_q;

	// digit shift register, most significant digit on top
	logic [pitts_pkg::BCD_W-1:0] dig_q;
	logic [DCNT_W-1:0]           dcnt_q;
	logic                        seen_q;

	// output register
	logic       out_valid_q;
	logic [7:0] out_char_q;
	logic       last_q;

	pitts_pkg::bcd_status_t      bcd_status;
	logic [pitts_pkg::BCD_W-1:0] bcd_digits;

	logic                          accept;
	logic                          ended_eff;
	logic [1:0]                    hdr_eff;
	logic [pitts_pkg::COUNT_W-1:0] done_inc;
	logic                          close_now;
	logic                          conv_start;
	logic                          dig_shift;
	logic                          out_ok;
	logic                          emit;
	logic [7:0]                    emit_char;
	logic                          emit_last;
	logic [3:0]                    top_nib;

	pitts_bcd_conv u_bcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (conv_start),
		.value  ({high_q, low_q}),
		.status (bcd_status),
		.digits (bcd_digits)
	);

	assign in_stall  = (state_q != pitts_pkg::ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign ended_eff = ended_q && !start_of_file;
	assign hdr_eff   = start_of_file ? pitts_pkg::HDR_LOW : hdr_q;
	assign done_inc  = done_q + 1'b1;
	assign close_now = (done_inc >= target_q);
	assign out_ok    = !out_valid_q || !out_stall;
	assign top_nib   = dig_q[pitts_pkg::BCD_W-1 -: 4];

	always_comb begin
		state_d    = state_q;
		conv_start = 1'b0;
		dig_shift  = 1'b0;
		emit       = 1'b0;
		emit_char  = pitts_pkg::CHAR_SPACE;
		emit_last  = 1'b0;
		unique case (state_q)
			pitts_pkg::ST_IDLE: begin
				if (accept && !ended_eff) begin
					if (hdr_eff == pitts_pkg::HDR_LEN) begin
						// zero line number ends the program silently
						if ({high_q, low_q} != '0) begin
							conv_start = 1'b1;
							state_d    = pitts_pkg::ST_CONV;
						end
					end else if (hdr_eff == pitts_pkg::HDR_TEXT) begin
						if (data_byte != 8'd0) begin
							state_d = pitts_pkg::ST_TEXT;
						end else if (close_now) begin
							state_d = pitts_pkg::ST_CR;
						end
					end
				end
			end
			pitts_pkg::ST_CONV: begin
				if (bcd_status.done) begin
					state_d = pitts_pkg::ST_DIGIT;
				end
			end
			pitts_pkg::ST_DIGIT: begin
				if (top_nib == 4'd0 && !seen_q) begin
					// leading zero: skip without output
					dig_shift = 1'b1;
					if (dcnt_q == DIGIT_LAST) begin
						state_d = pitts_pkg::ST_SPACE;
					end
				end else if (out_ok) begin
					emit      = 1'b1;
					emit_char = pitts_pkg::CHAR_ZERO | {4'd0, top_nib};
					dig_shift = 1'b1;
					if (dcnt_q == DIGIT_LAST) begin
						state_d = pitts_pkg::ST_SPACE;
					end
				end
			end
			pitts_pkg::ST_SPACE: begin
				if (out_ok) begin
					emit      = 1'b1;
					emit_char = pitts_pkg::CHAR_SPACE;
					emit_last = 1'b1;
					state_d   = pitts_pkg::ST_IDLE;
				end
			end
			pitts_pkg::ST_TEXT: begin
				if (out_ok) begin
					emit      = 1'b1;
					emit_char = text_q;
					emit_last = !close_q;
					state_d   = close_q ? pitts_pkg::ST_CR : pitts_pkg::ST_IDLE;
				end
			end
			pitts_pkg::ST_CR: begin
				if (out_ok) begin
					emit      = 1'b1;
					emit_char = pitts_pkg::CHAR_CR;
					state_d   = pitts_pkg::ST_LF;
				end
			end
			pitts_pkg::ST_LF: begin
				if (out_ok) begin
					emit      = 1'b1;
					emit_char = pitts_pkg::CHAR_LF;
					emit_last = 1'b1;
					state_d   = pitts_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pitts_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pitts_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// record state: start flag clears first, then the byte is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q    <= pitts_pkg::HDR_LOW;
			low_q    <= '0;
			high_q   <= '0;
			target_q <= '0;
			done_q   <= '0;
			ended_q  <= 1'b0;
		end else if (accept) begin
			if (start_of_file) begin
				// cleared record, the byte is the first header byte
				hdr_q    <= pitts_pkg::HDR_HIGH;
				low_q    <= data_byte;
				high_q   <= '0;
				target_q <= '0;
				done_q   <= '0;
				ended_q  <= 1'b0;
			end else if (!ended_eff) begin
				unique case (hdr_eff)
					pitts_pkg::HDR_LOW: begin
						low_q <= data_byte;
						hdr_q <= pitts_pkg::HDR_HIGH;
					end
					pitts_pkg::HDR_HIGH: begin
						high_q <= data_byte;
						hdr_q  <= pitts_pkg::HDR_LEN;
					end
					pitts_pkg::HDR_LEN: begin
						target_q <= {1'b0, data_byte} + 1'b1;
						done_q   <= '0;
						hdr_q    <= pitts_pkg::HDR_TEXT;
						if ({high_q, low_q} == '0) begin
							ended_q <= 1'b1;
						end
					end
					pitts_pkg::HDR_TEXT: begin
						done_q <= done_inc;
						if (close_now) begin
							hdr_q <= pitts_pkg::HDR_LOW;
						end
					end
					default: begin
						hdr_q <= pitts_pkg::HDR_LOW;
					end
				endcase
			end
		end
	end

	// pending text byte
	always_ff @(posedge clk) begin
		if (accept) begin
			text_q  <= data_byte;
			close_q <= close_now;
		end
	end

	// digit shifter, loaded when the conversion finishes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
			seen_q <= 1'b0;
		end else if (bcd_status.done) begin
			dcnt_q <= '0;
			seen_q <= 1'b0;
		end else if (dig_shift) begin
			dcnt_q <= dcnt_q + 1'b1;
			if (emit) begin
				seen_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (bcd_status.done) begin
			dig_q <= bcd_digits;
		end else if (dig_shift) begin
			dig_q <= {dig_q[pitts_pkg::BCD_W-5:0], 4'd0};
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ok) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ok && emit) begin
			out_char_q <= emit_char;
			last_q     <= emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign last      = last_q;

endmodule
`default_nettype wire

@@ bench/tb_program_image_to_text_stream.sv @@
`timescale 1ns / 100ps
// testbench for program_image_to_text_stream: drives program image bytes and checks listing chars
// depends on pitts_pkg and the program_image_to_text_stream rtl
module tb_program_image_to_text_stream;

	localparam int ITEM_TARGET    = 350;
	localparam int WATCHDOG_LIMIT = 2000;
	// the line number conversion is the slowest path
	localparam int DRAIN_CYCLES   = 40;
	localparam int MAX_REPORTS    = 10;

	// listing predictor plus the queue of characters still owed by the block
	class listing_checker;
		logic [1:0] hdr_pos;
		logic [7:0] line_lo;
		logic [7:0] line_hi;
		logic [8:0] text_len;
		logic [8:0] text_seen;
		bit         prog_done;
		logic [7:0] want_char[$];
		bit         want_last[$];
		int         errors;

		function new();
			clear();
			errors = 0;
		endfunction

		function void clear();
			hdr_pos   = pitts_pkg::HDR_LOW;
			line_lo   = '0;
			line_hi   = '0;
			text_len  = '0;
			text_seen = '0;
			prog_done = 1'b0;
		endfunction

		function void owe(logic [7:0] c);
			want_char.push_back(c);
			want_last.push_back(1'b0);
		endfunction

		// returns 0 when the byte falls after the end of the program and is dropped
		function bit take_byte(logic [7:0] b, logic sof);
			int         n_before;
			logic [15:0] line_no;
			logic [7:0] digits[$];
			n_before = want_char.size();
			if (sof)
				clear();
			if (prog_done)
				return 1'b0;
			case (hdr_pos)
				pitts_pkg::HDR_LOW: begin
					line_lo = b;
					hdr_pos = pitts_pkg::HDR_HIGH;
				end
				pitts_pkg::HDR_HIGH: begin
					line_hi = b;
					hdr_pos = pitts_pkg::HDR_LEN;
				end
				pitts_pkg::HDR_LEN: begin
					line_no   = {line_hi, line_lo};
					text_len  = {1'b0, b} + 9'd1;
					text_seen = '0;
					hdr_pos   = pitts_pkg::HDR_TEXT;
					if (line_no == 16'd0) begin
						prog_done = 1'b1;
					end else begin
						while (line_no != 16'd0) begin
							digits.push_front(pitts_pkg::CHAR_ZERO + 8'(line_no % 16'd10));
							line_no = line_no / 16'd10;
						end
						foreach (digits[i])
							owe(digits[i]);
						owe(pitts_pkg::CHAR_SPACE);
					end
				end
				default: begin
					if (b != 8'd0)
						owe(b);
					text_seen = text_seen + 9'd1;
					if (text_seen >= text_len) begin
						owe(pitts_pkg::CHAR_CR);
						owe(pitts_pkg::CHAR_LF);
						hdr_pos = pitts_pkg::HDR_LOW;
					end
				end
			endcase
			if (want_char.size() > n_before)
				want_last[want_last.size() - 1] = 1'b1;
			return 1'b1;
		endfunction

		function void report(string what, int exp_val, int act_val);
			errors++;
			if (errors <= MAX_REPORTS)
				$display("mismatch %s: expected %0h, got %0h", what, exp_val, act_val);
		endfunction

		function void check_char(logic [7:0] c, logic l);
			logic [7:0] exp_c;
			bit         exp_l;
			if (want_char.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("unexpected char %0h last %0b with nothing owed", c, l);
				return;
			end
			exp_c = want_char.pop_front();
			exp_l = want_last.pop_front();
			if (c !== exp_c)
				report("out_char", exp_c, c);
			if (l !== exp_l)
				report("last", exp_l, l);
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] data_byte = 8'd0;
	logic       start_of_file = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] out_char;
	logic       last;

	listing_checker listing = new();

	// idle and stall chances in percent, changed per phase
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	// input items taken by the block, not counting bytes dropped after the end
	int items_taken    = 0;
	int quiet_cycles   = 0;
	bit long_done      = 1'b0;

	program_image_to_text_stream i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.data_byte     (data_byte),
		.start_of_file (start_of_file),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_char      (out_char),
		.last          (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// output side: check each taken char, then pick the stall for the next cycle
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			listing.check_char(out_char, last);
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// watchdog on cycles in which neither channel moves an item
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
			$display("tb_program_image_to_text_stream: FAIL");
			$finish;
		end
	end

	// offer one image byte, hold it until the block takes it, then predict its chars
	task automatic send_image_byte(input logic [7:0] b, input logic sof);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		data_byte     <= b;
		start_of_file <= sof;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (listing.take_byte(b, sof))
			items_taken++;
	endtask

	// one program: start flag on the first byte, a few records, maybe the end marker
	// a broken program stops inside its last record
	task automatic send_program();
		int          n_rec;
		int          n_text;
		bit          broken;
		bit          sof_next;
		logic [15:0] line_no;
		logic [7:0]  len_byte;
		sof_next = 1'b1;
		n_rec    = $urandom_range(1, 6);
		broken   = ($urandom_range(4) == 0);
		for (int r = 0; r < n_rec; r++) begin
			case ($urandom_range(3))
				0:       line_no = 16'($urandom_range(1, 9));
				1:       line_no = 16'($urandom_range(10, 9999));
				2:       line_no = 16'($urandom_range(10000, 65535));
				default: line_no = 16'($urandom_range(1, 65535));
			endcase
			// force one longest record early on, then a rare one at random
			if (!long_done && items_taken >= 60) begin
				len_byte  = 8'd255;
				long_done = 1'b1;
			end else if ($urandom_range(59) == 0) begin
				len_byte = 8'd255;
			end else if ($urandom_range(7) == 0) begin
				len_byte = 8'($urandom_range(7, 40));
			end else begin
				len_byte = 8'($urandom_range(0, 6));
			end
			send_image_byte(line_no[7:0], sof_next);
			sof_next = 1'b0;
			if (broken && r == n_rec - 1 && $urandom_range(1) == 0)
				return;
			send_image_byte(line_no[15:8], 1'b0);
			send_image_byte(len_byte, 1'b0);
			n_text = int'(len_byte) + 1;
			if (broken && r == n_rec - 1)
				n_text = $urandom_range(0, n_text - 1);
			for (int i = 0; i < n_text; i++)
				send_image_byte(($urandom_range(3) == 0) ? 8'd0 : 8'($urandom_range(1, 255)),
					1'b0);
		end
		// end marker, then trailing bytes the block must swallow
		if (!broken && $urandom_range(1) == 0) begin
			send_image_byte(8'd0, 1'b0);
			send_image_byte(8'd0, 1'b0);
			send_image_byte(8'($urandom_range(255)), 1'b0);
			repeat ($urandom_range(0, 4))
				send_image_byte(8'($urandom_range(255)), 1'b0);
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, no idling
		// five digit line number gives the most chars per item
		send_image_byte(8'hFF, 1'b1);
		send_image_byte(8'hFF, 1'b0);
		send_image_byte(8'h03, 1'b0);
		send_image_byte(8'h01, 1'b0);
		// zero text byte inside the record stays silent
		send_image_byte(8'h00, 1'b0);
		send_image_byte(8'hFF, 1'b0);
		send_image_byte(8'h80, 1'b0);
		// single digit line, one zero text byte that closes the record: only CR LF
		send_image_byte(8'h01, 1'b0);
		send_image_byte(8'h00, 1'b0);
		send_image_byte(8'h00, 1'b0);
		send_image_byte(8'h00, 1'b0);
		// line 256, closing zero after a plain char
		send_image_byte(8'h00, 1'b0);
		send_image_byte(8'h01, 1'b0);
		send_image_byte(8'h01, 1'b0);
		send_image_byte(8'h7F, 1'b0);
		send_image_byte(8'h00, 1'b0);
		// line zero ends the program, following bytes are dropped
		send_image_byte(8'h00, 1'b0);
		send_image_byte(8'h00, 1'b0);
		send_image_byte(8'h05, 1'b0);
		send_image_byte(8'h41, 1'b0);
		send_image_byte(8'h00, 1'b0);
		// start flag restarts, then again in the middle of a header
		send_image_byte(8'h0A, 1'b1);
		send_image_byte(8'h00, 1'b0);
		send_image_byte(8'h02, 1'b1);
		send_image_byte(8'h00, 1'b0);
		send_image_byte(8'h00, 1'b0);
		send_image_byte(8'h41, 1'b0);

		// random part in four idling phases
		while (items_taken < ITEM_TARGET) begin
			case (items_taken * 4 / ITEM_TARGET)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 85;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 85;
				end
				default: begin
					send_idle_pct  = 17;
					recv_stall_pct = 17;
				end
			endcase
			if ($urandom_range(5) == 0) begin
				// noise: random bytes with a rare start flag
				repeat ($urandom_range(1, 8))
					send_image_byte(8'($urandom_range(255)), ($urandom_range(7) == 0));
			end else begin
				send_program();
			end
		end
		in_valid <= 1'b0;

		// drain: all owed chars, then a margin for anything extra
		while (listing.want_char.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (listing.errors == 0)
			$display("tb_program_image_to_text_stream: PASS");
		else
			$display("tb_program_image_to_text_stream: FAIL");
		$finish;
	end

endmodule
